// ===== src/c420ds_pkg.sv =====
`default_nettype none

package c420ds_pkg;

    localparam int PIX_W       = 8;
    localparam int ADDR_W      = 23;
    localparam int BLK_W       = 20;
    localparam int PSUM_W      = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = 2;
    localparam int LVL_W       = 3;

    localparam logic [CFG_DATA_W-1:0] MIN_SIZE     = 12'd2;
    localparam logic [CFG_DATA_W-1:0] RESET_WIDTH  = 12'd640;
    localparam logic [CFG_DATA_W-1:0] RESET_HEIGHT = 12'd480;

    localparam logic [1:0] PLANE_Y = 2'd0;
    localparam logic [1:0] PLANE_U = 2'd1;
    localparam logic [1:0] PLANE_V = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        PH_LUMA = 2'd0,
        PH_U    = 2'd1,
        PH_V    = 2'd2
    } t_phase;

    typedef struct packed {
        logic [PIX_W-1:0] luma_in;
        logic [PIX_W-1:0] cb_in;
        logic [PIX_W-1:0] cr_in;
    } t_pixel;

    typedef struct packed {
        logic [1:0]        plane;
        logic [ADDR_W-1:0] write_address;
        logic [PIX_W-1:0]  pixel_value;
        logic              last;
    } t_result;

    // one classified pixel waiting for the output side
    typedef struct packed {
        logic              is_block;
        logic [ADDR_W-1:0] luma_addr;
        logic [PIX_W-1:0]  luma;
        logic [PIX_W-1:0]  u_avg;
        logic [PIX_W-1:0]  v_avg;
        logic [BLK_W-1:0]  block;
    } t_job;

endpackage

`default_nettype wire

// ===== src/chroma_420_downsampler.sv =====
// channel  | handshake                      | payload
// ---------+--------------------------------+--------------------------------------
// pixels   | push / full                    | i_pixel  : luma_in, cb_in, cr_in
// results  | empty / pop                    | o_result : plane, write_address,
//          |                                |            pixel_value, last
// config   | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// one result leaves per cycle unless pop stalls; a pixel gives one result, or three
// when it closes a 2x2 block, so a frame with even sides averages one and a half
// results per pixel
// a pixel is taken every cycle while the four-entry job queue has room;
// its results pass the stage register, the job queue and the result register
// reset is synchronous: counters restart, queue and result register empty,
// line store keeps whatever it holds (it is always written before it is read)
// a stalled pop holds the result and backs up the queue, then raises full
`default_nettype none

module chroma_420_downsampler #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // pixel side
    input  wire                                 push,
    output logic                                full,
    input  c420ds_pkg::t_pixel                  i_pixel,
    // result side
    output logic                                empty,
    input  wire                                 pop,
    output c420ds_pkg::t_result                 o_result,
    // register writes
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [c420ds_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [c420ds_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import c420ds_pkg::*;

    // size compare width: holds the raw register and the largest frame side
    localparam int SZW = ($clog2(MAX_WIDTH + 1) > CFG_DATA_W) ?
                         $clog2(MAX_WIDTH + 1) : CFG_DATA_W;
    localparam int SZH = ($clog2(MAX_HEIGHT + 1) > CFG_DATA_W) ?
                         $clog2(MAX_HEIGHT + 1) : CFG_DATA_W;

    // configuration registers
    logic                  r_enable;
    logic [CFG_DATA_W-1:0] r_frame_width;
    logic [CFG_DATA_W-1:0] r_frame_height;

    logic                  cfg_we;
    logic                  restart;
    logic [SZW-1:0]        width_c;
    logic [SZH-1:0]        height_c;
    logic [SZW+SZH-1:0]    area_full;
    logic [ADDR_W-1:0]     r_area;
    logic [ADDR_W-1:0]     r_quarter;

    // between the parts
    logic                  job_push;
    t_job                  job_in;
    t_job                  job_head;
    logic                  job_empty;
    logic                  job_deq;
    logic [LVL_W-1:0]      job_level;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    // a new frame size starts a new frame
    assign restart     = cfg_we && ((t_cfg_index'(i_cfg_index) == CFG_WIDTH) ||
                                    (t_cfg_index'(i_cfg_index) == CFG_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable       <= 1'b0;
            r_frame_width  <= RESET_WIDTH;
            r_frame_height <= RESET_HEIGHT;
        end else if (cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_ENABLE: r_enable       <= i_cfg_data[0];
                CFG_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_HEIGHT: r_frame_height <= i_cfg_data;
                default:    r_enable       <= r_enable;
            endcase
        end
    end

    // saturate the sizes into the supported range
    always_comb begin
        if (r_frame_width < MIN_SIZE) begin
            width_c = SZW'(MIN_SIZE);
        end else if (SZW'(r_frame_width) > SZW'(MAX_WIDTH)) begin
            width_c = SZW'(MAX_WIDTH);
        end else begin
            width_c = SZW'(r_frame_width);
        end
        if (r_frame_height < MIN_SIZE) begin
            height_c = SZH'(MIN_SIZE);
        end else if (SZH'(r_frame_height) > SZH'(MAX_HEIGHT)) begin
            height_c = SZH'(MAX_HEIGHT);
        end else begin
            height_c = SZH'(r_frame_height);
        end
        area_full = (SZW+SZH)'(width_c) * (SZW+SZH)'(height_c);
    end

    // plane bases, refreshed every cycle from the size registers
    always_ff @(posedge i_clk) begin
        r_area    <= ADDR_W'(area_full);
        r_quarter <= ADDR_W'(area_full >> 2);
    end

    c420ds_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .SZW        (SZW),
        .SZH        (SZH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_pixel    (i_pixel),
        .i_enable   (r_enable),
        .i_width    (width_c),
        .i_height   (height_c),
        .i_restart  (restart),
        .i_level    (job_level),
        .o_full     (full),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    c420ds_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_deq),
        .o_job   (job_head),
        .o_empty (job_empty),
        .o_level (job_level)
    );

    c420ds_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_head),
        .i_job_empty (job_empty),
        .i_area      (r_area),
        .i_quarter   (r_quarter),
        .i_pop       (pop),
        .o_deq       (job_deq),
        .o_empty     (empty),
        .o_result    (o_result)
    );

    // the job queue never overfills, thanks to the reservation in full
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_level <= LVL_W'(QUEUE_DEPTH))
        else $error("job queue overfilled");

    // a taken luma result that is not last is followed by its U result
    a_luma_then_u: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_result.plane == PLANE_Y && !o_result.last)
        |=> (!empty && o_result.plane == PLANE_U))
        else $error("block luma not followed by U");

    // a taken U result is followed by its V result
    a_u_then_v: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_result.plane == PLANE_U)
        |=> (!empty && o_result.plane == PLANE_V && o_result.last))
        else $error("U result not followed by last V");

    // chroma never ends a pixel except on the V plane
    a_u_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.plane == PLANE_U) |-> !o_result.last)
        else $error("U result marked last");

endmodule

`default_nettype wire

// ===== src/c420ds_queue.sv =====
`default_nettype none

module c420ds_queue (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_push,
    input  c420ds_pkg::t_job                    i_job,
    input  wire                                 i_pop,
    output c420ds_pkg::t_job                    o_job,
    output logic                                o_empty,
    output logic [c420ds_pkg::LVL_W-1:0]        o_level
);
    import c420ds_pkg::*;

    t_job             r_slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [LVL_W-1:0] r_level;
    logic             pop_ok;

    assign pop_ok  = i_pop && (r_level != '0);
    assign o_empty = (r_level == '0);
    assign o_level = r_level;
    assign o_job   = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, pop_ok})
                2'b10:   r_level <= r_level + LVL_W'(1);
                2'b01:   r_level <= r_level - LVL_W'(1);
                default: r_level <= r_level;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ===== src/c420ds_front.sv =====
`default_nettype none

module c420ds_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int SZW        = 12,
    parameter int SZH        = 12
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_push,
    input  c420ds_pkg::t_pixel              i_pixel,
    input  wire                             i_enable,
    input  wire  [SZW-1:0]                  i_width,
    input  wire  [SZH-1:0]                  i_height,
    input  wire                             i_restart,
    input  wire  [c420ds_pkg::LVL_W-1:0]    i_level,
    output logic                            o_full,
    output logic                            o_job_push,
    output c420ds_pkg::t_job                o_job
);
    import c420ds_pkg::*;

    localparam int CW         = ($clog2(MAX_WIDTH) > 2) ? $clog2(MAX_WIDTH) : 2;
    localparam int RW         = ($clog2(MAX_HEIGHT) > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int LAW        = CW - 1;
    localparam int LINE_DEPTH = 2 ** LAW;

    typedef struct packed {
        logic              is_block;
        logic [ADDR_W-1:0] luma_addr;
        logic [PIX_W-1:0]  luma;
        logic [PSUM_W-1:0] usum;
        logic [PSUM_W-1:0] vsum;
        logic [BLK_W-1:0]  block;
    } t_stage;

    logic [CW-1:0]       r_col;
    logic [RW-1:0]       r_row;
    logic [ADDR_W-1:0]   r_luma;
    logic [BLK_W-1:0]    r_blk;
    logic [2*PIX_W-1:0]  r_left;
    logic [2*PSUM_W-1:0] r_line [LINE_DEPTH];
    logic [2*PSUM_W-1:0] r_held;
    t_stage              r_s1;
    logic                r_s1_valid;

    logic                act;
    logic                wrap;
    logic [CW-1:0]       cur_col;
    logic [RW-1:0]       cur_row;
    logic [ADDR_W-1:0]   cur_luma;
    logic [BLK_W-1:0]    cur_blk;
    logic [LAW-1:0]      slot;
    logic [PSUM_W-1:0]   usum;
    logic [PSUM_W-1:0]   vsum;
    logic [SZW-1:0]      col_nx;
    logic [SZH-1:0]      row_nx;
    logic                row_end;
    logic                frame_end;
    logic                is_block;
    logic [PSUM_W:0]     u_total;
    logic [PSUM_W:0]     v_total;

    // room is reserved for the item in the second stage as well
    assign o_full = (LVL_W'(i_level) + LVL_W'(r_s1_valid)) >= LVL_W'(QUEUE_DEPTH);
    assign act    = i_push && !o_full && i_enable;

    always_comb begin
        wrap      = (SZW'(r_col) >= i_width) || (SZH'(r_row) >= i_height);
        cur_col   = wrap ? '0 : r_col;
        cur_row   = wrap ? '0 : r_row;
        cur_luma  = wrap ? '0 : r_luma;
        cur_blk   = wrap ? '0 : r_blk;
        slot      = cur_col[CW-1:1];
        usum      = PSUM_W'(r_left[2*PIX_W-1:PIX_W]) + PSUM_W'(i_pixel.cb_in);
        vsum      = PSUM_W'(r_left[PIX_W-1:0]) + PSUM_W'(i_pixel.cr_in);
        col_nx    = SZW'(cur_col) + SZW'(1);
        row_nx    = SZH'(cur_row) + SZH'(1);
        row_end   = (col_nx >= i_width);
        frame_end = row_end && (row_nx >= i_height);
        is_block  = cur_col[0] && cur_row[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_luma     <= '0;
            r_blk      <= '0;
            r_left     <= '0;
            r_s1_valid <= 1'b0;
        end else if (i_restart) begin
            r_col      <= '0;
            r_row      <= '0;
            r_luma     <= '0;
            r_blk      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= act;
            if (act) begin
                if (!cur_col[0]) begin
                    r_left <= {i_pixel.cb_in, i_pixel.cr_in};
                end
                if (frame_end) begin
                    r_col  <= '0;
                    r_row  <= '0;
                    r_luma <= '0;
                    r_blk  <= '0;
                end else begin
                    r_luma <= cur_luma + ADDR_W'(1);
                    r_blk  <= cur_blk + BLK_W'(is_block);
                    if (row_end) begin
                        r_col <= '0;
                        r_row <= RW'(row_nx);
                    end else begin
                        r_col <= CW'(col_nx);
                        r_row <= cur_row;
                    end
                end
            end
        end
    end

    // line store of pair sums: even rows write, odd rows read
    always_ff @(posedge i_clk) begin
        if (act && cur_col[0] && !cur_row[0]) begin
            r_line[slot] <= {vsum, usum};
        end
        if (act && is_block) begin
            r_held <= r_line[slot];
        end
        if (act) begin
            r_s1.is_block  <= is_block;
            r_s1.luma_addr <= cur_luma;
            r_s1.luma      <= i_pixel.luma_in;
            r_s1.usum      <= usum;
            r_s1.vsum      <= vsum;
            r_s1.block     <= cur_blk;
        end
    end

    // second stage: finish the block averages
    always_comb begin
        u_total          = (PSUM_W+1)'(r_held[PSUM_W-1:0]) + (PSUM_W+1)'(r_s1.usum);
        v_total          = (PSUM_W+1)'(r_held[2*PSUM_W-1:PSUM_W]) + (PSUM_W+1)'(r_s1.vsum);
        o_job_push       = r_s1_valid;
        o_job.is_block   = r_s1.is_block;
        o_job.luma_addr  = r_s1.luma_addr;
        o_job.luma       = r_s1.luma;
        o_job.u_avg      = u_total[PSUM_W:2];
        o_job.v_avg      = v_total[PSUM_W:2];
        o_job.block      = r_s1.block;
    end

endmodule

`default_nettype wire

// ===== src/c420ds_back.sv =====
`default_nettype none

module c420ds_back (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  c420ds_pkg::t_job                    i_job,
    input  wire                                 i_job_empty,
    input  wire  [c420ds_pkg::ADDR_W-1:0]       i_area,
    input  wire  [c420ds_pkg::ADDR_W-1:0]       i_quarter,
    input  wire                                 i_pop,
    output logic                                o_deq,
    output logic                                o_empty,
    output c420ds_pkg::t_result                 o_result
);
    import c420ds_pkg::*;

    t_phase  r_phase;
    t_phase  n_phase;
    logic    r_valid;
    t_result r_result;
    t_result n_result;
    logic    load;

    assign load     = !r_valid || i_pop;
    assign o_empty  = !r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LUMA;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (load) begin
                r_valid <= !i_job_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_job_empty) begin
            r_result <= n_result;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        o_deq    = 1'b0;
        n_result = '0;
        unique case (r_phase)
            PH_LUMA: begin
                n_result.plane         = PLANE_Y;
                n_result.write_address = i_job.luma_addr;
                n_result.pixel_value   = i_job.luma;
                n_result.last          = !i_job.is_block;
                if (load && !i_job_empty) begin
                    if (i_job.is_block) begin
                        n_phase = PH_U;
                    end else begin
                        o_deq = 1'b1;
                    end
                end
            end
            PH_U: begin
                n_result.plane         = PLANE_U;
                n_result.write_address = i_area + ADDR_W'(i_job.block);
                n_result.pixel_value   = i_job.u_avg;
                n_result.last          = 1'b0;
                if (load && !i_job_empty) begin
                    n_phase = PH_V;
                end
            end
            PH_V: begin
                n_result.plane         = PLANE_V;
                n_result.write_address = i_area + i_quarter + ADDR_W'(i_job.block);
                n_result.pixel_value   = i_job.v_avg;
                n_result.last          = 1'b1;
                if (load && !i_job_empty) begin
                    n_phase = PH_LUMA;
                    o_deq   = 1'b1;
                end
            end
            default: begin
                n_phase = PH_LUMA;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== tb/sv/c420ds_checker.sv =====
`timescale 1ns / 100ps

module c420ds_checker (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_push,
    input  wire                                 i_full,
    input  c420ds_pkg::t_pixel                  i_pixel,
    input  wire                                 i_empty,
    input  wire                                 i_pop,
    input  c420ds_pkg::t_result                 i_result,
    input  wire                                 i_cfg_valid,
    input  wire                                 i_cfg_ready,
    input  wire  [c420ds_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [c420ds_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                  o_pending,
    output int                                  o_fail_count
);
    import c420ds_pkg::*;

    localparam int unsigned SIDE_MAX   = 2048;
    localparam int          LINE_SLOTS = SIDE_MAX / 2;

    // mirrored registers
    logic                  enabled;
    logic [CFG_DATA_W-1:0] frame_width;
    logic [CFG_DATA_W-1:0] frame_height;

    // raster position and chroma history
    logic [10:0]           col;
    logic [10:0]           row;
    logic [BLK_W-1:0]      block;
    logic [15:0]           left_chroma;
    logic [17:0]           pair_line [LINE_SLOTS];

    t_result               pending_writes [$];
    int                    fail_count = 0;
    int                    writes_seen = 0;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
        for (int k = 0; k < LINE_SLOTS; k++) pair_line[k] = '0;
    end

    function automatic int unsigned fit_size(input logic [CFG_DATA_W-1:0] v);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > SIDE_MAX) return SIDE_MAX;
        return v;
    endfunction

    task automatic restart_frame();
        col   = '0;
        row   = '0;
        block = '0;
    endtask

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("c420ds_checker: %s", msg);
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ENABLE: begin
                enabled = data[0];
            end
            CFG_WIDTH: begin
                frame_width = data;
                restart_frame();
            end
            CFG_HEIGHT: begin
                frame_height = data;
                restart_frame();
            end
            default: begin
            end
        endcase
    endtask

    // one enabled pixel in, one or three plane writes out
    task automatic convert_pixel(input t_pixel px);
        int unsigned w;
        int unsigned h;
        int unsigned area;
        logic [8:0]  u_pair;
        logic [8:0]  v_pair;
        logic [9:0]  quad;
        logic [17:0] held;
        t_result     wr;
        if (enabled) begin
            w = fit_size(frame_width);
            h = fit_size(frame_height);
            if (col >= w || row >= h) restart_frame();
            area = w * h;
            wr.plane         = PLANE_Y;
            wr.write_address = ADDR_W'(row * w + col);
            wr.pixel_value   = px.luma_in;
            wr.last          = 1'b1;
            if (!col[0]) begin
                left_chroma = {px.cb_in, px.cr_in};
                pending_writes.push_back(wr);
            end else begin
                u_pair = {1'b0, left_chroma[15:8]} + px.cb_in;
                v_pair = {1'b0, left_chroma[7:0]} + px.cr_in;
                if (!row[0]) begin
                    pair_line[col[10:1]] = {v_pair, u_pair};
                    pending_writes.push_back(wr);
                end else begin
                    held    = pair_line[col[10:1]];
                    wr.last = 1'b0;
                    pending_writes.push_back(wr);
                    quad             = held[8:0] + u_pair;
                    wr.plane         = PLANE_U;
                    wr.write_address = ADDR_W'(area + block);
                    wr.pixel_value   = quad[9:2];
                    pending_writes.push_back(wr);
                    quad             = held[17:9] + v_pair;
                    wr.plane         = PLANE_V;
                    wr.write_address = ADDR_W'(area + area / 4 + block);
                    wr.pixel_value   = quad[9:2];
                    wr.last          = 1'b1;
                    pending_writes.push_back(wr);
                    block = block + 1'b1;
                end
            end
            if (col + 1 >= w) begin
                col = '0;
                if (row + 1 >= h) restart_frame();
                else row = row + 1'b1;
            end else begin
                col = col + 1'b1;
            end
        end
    endtask

    task automatic check_write(input t_result got);
        t_result want;
        writes_seen++;
        if (pending_writes.size() == 0) begin
            report_mismatch($sformatf("write %0d unexpected: plane %0d addr %0d value %0d last %0b",
                writes_seen, got.plane, got.write_address, got.pixel_value, got.last));
        end else begin
            want = pending_writes.pop_front();
            if (got.plane != want.plane || got.write_address != want.write_address ||
                    got.pixel_value != want.pixel_value || got.last !== want.last) begin
                report_mismatch($sformatf(
                    "write %0d: got %0d/%0d/%0d/%0b want %0d/%0d/%0d/%0b (plane/addr/value/last)",
                    writes_seen, got.plane, got.write_address, got.pixel_value, got.last,
                    want.plane, want.write_address, want.pixel_value, want.last));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            enabled      = 1'b0;
            frame_width  = RESET_WIDTH;
            frame_height = RESET_HEIGHT;
            left_chroma  = '0;
            restart_frame();
            pending_writes.delete();
        end else begin
            if (i_pop && !i_empty) check_write(i_result);
            if (i_cfg_valid && i_cfg_ready) write_setting(i_cfg_index, i_cfg_data);
            if (i_push && !i_full) convert_pixel(i_pixel);
        end
        o_pending    <= pending_writes.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== tb/sv/tb_chroma_420_downsampler.sv =====
`timescale 1ns / 100ps

module tb_chroma_420_downsampler;
    import c420ds_pkg::*;

    localparam int RANDOM_PIXELS = 180;
    localparam int IDLE_PERCENT  = 31;
    // first write passes the stage register, the job queue and the result register; give it room
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 80;
    localparam int CYCLE_LIMIT   = 200000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;

    // pixel side
    logic                  push = 1'b0;
    logic                  full;
    t_pixel                pixel_in = '0;

    // result side
    logic                  empty;
    logic                  pop = 1'b0;
    t_result               result_out;

    // register writes
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_ENABLE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // from the checker
    int                    pending;
    int                    fail_count;

    // shared between the two driving processes
    bit                    steady = 1'b0;
    int                    hold_requests = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    chroma_420_downsampler u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .push        (push),
        .full        (full),
        .i_pixel     (pixel_in),
        .empty       (empty),
        .pop         (pop),
        .o_result    (result_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    c420ds_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_pixel      (pixel_in),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (result_out),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // mostly uniform bytes, with the rails showing up often
    function automatic logic [PIX_W-1:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic t_pixel random_pixel();
        t_pixel px;
        px.luma_in = pick_byte();
        px.cb_in   = pick_byte();
        px.cr_in   = pick_byte();
        return px;
    endfunction

    // offer one item, idling first at random unless in the steady stretch;
    // push stays high on return so the next item can follow back to back
    task automatic send_pixel(input t_pixel px);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push     <= 1'b1;
        pixel_in <= px;
        do @(posedge clk); while (!(push && !full));
    endtask

    // stop offering, wait for every predicted write, then let the pipe settle
    // since ignored pixels may still be in flight with nothing predicted
    task automatic drain_block();
        push <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // leaves valid high so a second write can follow in the next cycle
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        reg_write(CFG_WIDTH, w);
        reg_write(CFG_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_enable(input logic en);
        reg_write(CFG_ENABLE, {{(CFG_DATA_W-1){1'b0}}, en});
        cfg_valid <= 1'b0;
    endtask

    // result side: random stalls, plus one long hold-off on request that
    // backs the job queue up until full rises
    initial begin : result_side
        int hold_served;
        hold_served = 0;
        forever begin
            @(posedge clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                pop <= steady || $urandom_range(99) >= IDLE_PERCENT;
            end
        end
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_chroma_420_downsampler: FAIL");
        $finish;
    end

    initial begin : stimulus
        int                    converted;
        int                    run;
        logic [CFG_DATA_W-1:0] w;
        logic [CFG_DATA_W-1:0] h;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed part ---

        // out of reset the block is disabled: these items must vanish
        send_pixel({8'h00, 8'h00, 8'h00});
        send_pixel({8'hFF, 8'hFF, 8'hFF});
        drain_block();
        set_enable(1'b1);

        // reset frame size 640x480, start of the first row, luma only
        send_pixel({8'hFF, 8'h00, 8'hFF});
        send_pixel({8'h00, 8'hFF, 8'h00});
        send_pixel({8'hA5, 8'h5A, 8'hC3});
        drain_block();

        // all-ones width saturates to the widest row, zero height to two rows
        set_frame(12'hFFF, 12'h000);
        send_pixel(random_pixel());
        send_pixel(random_pixel());
        drain_block();

        // width one saturates up to 2: a full 2x2 frame, then the wrap into
        // the next frame with block index back at zero
        set_frame(12'd1, 12'd2);
        repeat (4) send_pixel({8'hFF, 8'hFF, 8'hFF});
        // chroma sums of 6 truncate to an average of 1
        send_pixel({8'h01, 8'h00, 8'h03});
        send_pixel({8'h02, 8'h01, 8'h02});
        send_pixel({8'h03, 8'h02, 8'h01});
        send_pixel({8'h04, 8'h03, 8'h00});
        drain_block();

        // odd sides: last column and last row give luma only
        set_frame(12'd3, 12'd3);
        repeat (9) send_pixel(random_pixel());

        // --- random part: whole raster runs at random frame sizes ---
        converted = 0;
        while (converted < RANDOM_PIXELS) begin
            drain_block();
            case ($urandom_range(9))
                0: begin
                    // widest rows, few pixels: only the first row gets touched
                    w = CFG_DATA_W'($urandom_range(2048, 4095));
                    h = CFG_DATA_W'($urandom_range(0, 3));
                end
                1: begin
                    // tallest frames, narrow rows: big plane offsets
                    w = CFG_DATA_W'($urandom_range(0, 4));
                    h = CFG_DATA_W'($urandom_range(2048, 4095));
                end
                default: begin
                    w = CFG_DATA_W'($urandom_range(2, 8));
                    h = CFG_DATA_W'($urandom_range(2, 6));
                end
            endcase
            set_frame(w, h);

            // long stall on the result side while pixels keep coming
            if (converted >= 30 && hold_requests == 0) hold_requests++;

            run = $urandom_range(12, 40);
            repeat (run) begin
                // no idling on either side for a while
                steady = converted >= 70 && converted < 130;

                // sender waits for every write before carrying on
                if (converted == 150) drain_block();

                // disable mid-frame: ignored pixels, position kept on re-enable
                if ($urandom_range(29) == 0) begin
                    drain_block();
                    set_enable(1'b0);
                    repeat ($urandom_range(1, 3)) send_pixel(random_pixel());
                    drain_block();
                    set_enable(1'b1);
                end

                send_pixel(random_pixel());
                converted++;
            end
        end

        drain_block();
        if (fail_count == 0) begin
            $display("tb_chroma_420_downsampler: PASS");
        end else begin
            $display("tb_chroma_420_downsampler: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/c420ds_pkg.sv
src/c420ds_queue.sv
src/c420ds_front.sv
src/c420ds_back.sv
src/chroma_420_downsampler.sv
tb/sv/c420ds_checker.sv
tb/sv/tb_chroma_420_downsampler.sv
